// ===== hdl/htsa_pkg.sv =====
// ----------------------------------------------------------------------------
// htsa_pkg
// types and constants shared by the header table size accounting block
// ----------------------------------------------------------------------------
package htsa_pkg;

    localparam int unsigned LEN_W    = 14;
    localparam int unsigned BYTES_W  = 16;
    localparam int unsigned COUNT_W  = 7;

    // per-entry overhead counted against the byte budget
    localparam logic [BYTES_W-1:0] ENTRY_OVERHEAD = 16'd32;
    localparam logic [BYTES_W-1:0] BUDGET_RESET   = 16'd4096;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_TRIM   = 1'b1;

    typedef struct packed {
        logic             func;
        logic [LEN_W-1:0] name_length;
        logic [LEN_W-1:0] value_length;
    } t_in_req;

    typedef struct packed {
        logic [BYTES_W-1:0] table_bytes;
        logic [COUNT_W-1:0] entry_count;
        logic [COUNT_W-1:0] evicted_count;
        logic               inserted;
        logic               cleared;
    } t_out_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SETTLE,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic drop;
        logic insert;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_insert;
        logic oversize;
        logic need_evict;
    } t_status;

endpackage

// ===== hdl/htsa_datapath.sv =====
// ----------------------------------------------------------------------------
// htsa_datapath
// ring of entry sizes, occupancy and byte total, budget register, result register
// ----------------------------------------------------------------------------
module htsa_datapath
    import htsa_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  t_in_req             i_in_req,
    input  logic                i_cfg_we,
    input  logic [BYTES_W-1:0]  i_cfg_wdata,
    output t_out_req            o_out_req
);

    localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned SW  = AW + 1;
    localparam int unsigned CXW = CW + COUNT_W;

    logic [BYTES_W-1:0] r_mem [MAX_ENTRIES];
    logic [BYTES_W-1:0] r_rd_data;

    logic [AW-1:0]      r_oldest,  n_oldest;
    logic [CW-1:0]      r_held,    n_held;
    logic [BYTES_W-1:0] r_total,   n_total;
    logic [CW-1:0]      r_evicted, n_evicted;
    logic               r_ins,     n_ins;
    logic               r_clr,     n_clr;
    logic [BYTES_W-1:0] r_budget;
    logic [BYTES_W-1:0] r_size;
    logic               r_func;
    t_out_req           r_out;

    logic [SW-1:0]      w_slot_sum;
    logic [AW-1:0]      w_wr_addr;
    logic [BYTES_W:0]   w_fit_sum;
    logic               w_full;
    logic [CXW-1:0]     w_held_ext;
    logic [CXW-1:0]     w_evicted_ext;

    // newest slot follows the held entries, wrapped into the ring
    assign w_slot_sum = SW'(r_oldest) + SW'(r_held);
    assign w_wr_addr  = (w_slot_sum >= SW'(MAX_ENTRIES))
                      ? AW'(w_slot_sum - SW'(MAX_ENTRIES)) : AW'(w_slot_sum);

    assign w_fit_sum = {1'b0, r_total} + {1'b0, r_size};
    assign w_full    = (r_held >= CW'(MAX_ENTRIES));

    always_comb begin
        o_status.is_insert = (r_func == FUNC_INSERT);
        o_status.oversize  = (r_size > r_budget);
        if (r_func == FUNC_TRIM) begin
            o_status.need_evict = (r_held != '0) && (r_total > r_budget);
        end else begin
            o_status.need_evict = (r_held != '0)
                               && ((w_fit_sum > {1'b0, r_budget}) || w_full);
        end
    end

    // entry size store: one write, one registered read at the oldest slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_mem[w_wr_addr] <= r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_oldest];
    end

    always_comb begin
        n_oldest  = r_oldest;
        n_held    = r_held;
        n_total   = r_total;
        n_evicted = r_evicted;
        n_ins     = r_ins;
        n_clr     = r_clr;
        priority if (i_cmd.capture) begin
            n_evicted = '0;
            n_ins     = 1'b0;
            n_clr     = 1'b0;
        end else if (i_cmd.clear) begin
            n_evicted = r_held;
            n_held    = '0;
            n_total   = '0;
            n_oldest  = '0;
            n_clr     = 1'b1;
        end else if (i_cmd.drop) begin
            n_total   = (r_rd_data > r_total) ? '0 : r_total - r_rd_data;
            n_oldest  = (r_oldest == AW'(MAX_ENTRIES - 1)) ? '0 : r_oldest + 1'b1;
            n_held    = r_held - 1'b1;
            n_evicted = r_evicted + 1'b1;
        end else if (i_cmd.insert) begin
            n_held    = r_held + 1'b1;
            n_total   = w_fit_sum[BYTES_W-1:0];
            n_ins     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_held    <= '0;
            r_total   <= '0;
            r_evicted <= '0;
            r_ins     <= 1'b0;
            r_clr     <= 1'b0;
            r_budget  <= BUDGET_RESET;
        end else begin
            r_oldest  <= n_oldest;
            r_held    <= n_held;
            r_total   <= n_total;
            r_evicted <= n_evicted;
            r_ins     <= n_ins;
            r_clr     <= n_clr;
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
        end
    end

    // request operands, held for the whole item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_in_req.func;
            r_size <= BYTES_W'(i_in_req.name_length) + BYTES_W'(i_in_req.value_length)
                    + ENTRY_OVERHEAD;
        end
    end

    assign w_held_ext    = CXW'(r_held);
    assign w_evicted_ext = CXW'(r_evicted);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.table_bytes   <= r_total;
            r_out.entry_count   <= w_held_ext[COUNT_W-1:0];
            r_out.evicted_count <= w_evicted_ext[COUNT_W-1:0];
            r_out.inserted      <= r_ins;
            r_out.cleared       <= r_clr;
        end
    end

    assign o_out_req = r_out;

    a_held_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(MAX_ENTRIES))
        else $error("occupancy above ring depth");

    a_oldest_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oldest <= AW'(MAX_ENTRIES - 1))
        else $error("oldest slot outside ring");

    a_drop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop |-> (r_held != '0))
        else $error("eviction from empty table");

    a_ins_clr_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ins && r_clr))
        else $error("entry both inserted and cleared");

endmodule

// ===== hdl/htsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// htsa_ctrl
// sequencer for insert, evict and trim, plus result handshake
// ----------------------------------------------------------------------------
module htsa_ctrl
    import htsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_status.is_insert && i_status.oversize) begin
                    n_state = S_FINISH;
                end else if (i_status.need_evict) begin
                    n_state = S_SETTLE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SETTLE: begin
                n_state = S_EVAL;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EVAL: begin
                priority if (i_status.is_insert && i_status.oversize) begin
                    o_cmd.clear = 1'b1;
                end else if (i_status.need_evict) begin
                    o_cmd.drop = 1'b1;
                end else if (i_status.is_insert) begin
                    o_cmd.insert = 1'b1;
                end
            end
            S_SETTLE: begin
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.clear, o_cmd.drop, o_cmd.insert, o_cmd.load_out}))
        else $error("more than one datapath command");

    a_drop_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drop |=> (r_state == S_SETTLE))
        else $error("eviction not followed by read settle");

    a_load_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while waiting");

endmodule

// ===== hdl/header_table_size_accounting_top.sv =====
// ----------------------------------------------------------------------------
// header_table_size_accounting_top
// size bookkeeping of a header compression dynamic table with oldest-first eviction
// ----------------------------------------------------------------------------
// Each request either inserts an entry (func 0, size = name + value + 32 bytes)
// or trims the table to the byte budget (func 1); exactly one result request
// follows each input request. Entry sizes live in a ring memory of MAX_ENTRIES
// words with one write port and one registered read port fixed on the oldest
// slot. A request passes through accept, evaluate and result load, and each
// evicted entry adds a pop of the oldest size and a wait for the registered
// read of the next oldest slot to come through; an oversized insert empties
// the table with a single clear command from evaluate. Input and output are
// decoupled by the result register, so a new request is accepted while the
// previous result still waits. The budget register resets to 4096 and must
// only be written while the block is idle; no clearing pass is needed after
// reset since only entries that were written are ever read.
// ----------------------------------------------------------------------------
module header_table_size_accounting_top
    import htsa_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_req             i_in_req,
    // result request channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_req            o_out_req,
    // budget register write
    input  logic                i_cfg_we,
    input  logic [BYTES_W-1:0]  i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: decides clear, evict or insert from datapath status
    htsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // ring memory, counters, byte total and result register
    htsa_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_req   (o_out_req)
    );

endmodule

// ===== sim/htsa_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// htsa_tb_pkg
// table size tracker and result scoreboard for the header table accounting test
// ----------------------------------------------------------------------------
package htsa_tb_pkg;

    import htsa_pkg::*;

    localparam int unsigned RING_DEPTH    = 64;
    localparam int unsigned REPORT_LIMIT  = 10;

    class htsa_table_tracker;

        logic [BYTES_W-1:0] budget;
        logic [BYTES_W-1:0] ring_sizes [RING_DEPTH];
        int unsigned        tail_slot;
        int unsigned        held;
        int unsigned        total;
        t_out_req           results_due [$];
        int unsigned        mismatches;

        function new();
            budget     = BUDGET_RESET;
            tail_slot  = 0;
            held       = 0;
            total      = 0;
            mismatches = 0;
        endfunction

        function void set_budget(logic [BYTES_W-1:0] value);
            budget = value;
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        // pop the oldest entry, total saturates at zero
        function void evict_oldest();
            int unsigned sz;
            sz        = ring_sizes[tail_slot];
            total     = (sz > total) ? 0 : total - sz;
            tail_slot = (tail_slot + 1) % RING_DEPTH;
            held--;
        endfunction

        function void note_request(t_in_req req);
            t_out_req    res;
            int unsigned sz;
            int unsigned evicted;
            res     = '0;
            evicted = 0;
            if (req.func == FUNC_INSERT) begin
                sz = req.name_length + req.value_length + ENTRY_OVERHEAD;
                if (sz > budget) begin
                    evicted     = held;
                    held        = 0;
                    total       = 0;
                    tail_slot   = 0;
                    res.cleared = 1'b1;
                end else begin
                    while (held > 0 && (total + sz > budget || held >= RING_DEPTH)) begin
                        evict_oldest();
                        evicted++;
                    end
                    ring_sizes[(tail_slot + held) % RING_DEPTH] = sz[BYTES_W-1:0];
                    held++;
                    total        = (total + sz) & 32'hFFFF;
                    res.inserted = 1'b1;
                end
            end else begin
                while (held > 0 && total > budget) begin
                    evict_oldest();
                    evicted++;
                end
            end
            res.table_bytes   = total[BYTES_W-1:0];
            res.entry_count   = held[COUNT_W-1:0];
            res.evicted_count = evicted[COUNT_W-1:0];
            results_due       = {results_due, res};
        endfunction

        function void check_result(t_out_req got);
            t_out_req want;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: bytes=%0d entries=%0d evicted=%0d ins=%0b clr=%0b",
                             got.table_bytes, got.entry_count, got.evicted_count,
                             got.inserted, got.cleared);
                return;
            end
            want = results_due.pop_front();
            if (got.table_bytes !== want.table_bytes || got.entry_count !== want.entry_count ||
                got.evicted_count !== want.evicted_count || got.inserted !== want.inserted ||
                got.cleared !== want.cleared) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result mismatch: expected bytes=%0d entries=%0d evicted=%0d ",
                              "ins=%0b clr=%0b, got bytes=%0d entries=%0d evicted=%0d ",
                              "ins=%0b clr=%0b"},
                             want.table_bytes, want.entry_count, want.evicted_count,
                             want.inserted, want.cleared, got.table_bytes, got.entry_count,
                             got.evicted_count, got.inserted, got.cleared);
            end
        endfunction

    endclass

endpackage

// ===== sim/header_table_size_accounting_top_test.sv =====
// ----------------------------------------------------------------------------
// header_table_size_accounting_top_test
// self-checking test of the dynamic header table size bookkeeping
// ----------------------------------------------------------------------------
// A directed run walks the corners (smallest and largest entries, oversized
// entries that empty the table, exact fits, trims on an empty table, a budget
// lowered without a trim, zero and full-scale budgets). Then ten random phases
// each write a new budget and send random insert and trim requests, one phase
// filling the ring past its depth with small entries. Every accepted request
// is run through a tracker of the table which queues the expected result;
// each result request is checked against the oldest queued one.
// ----------------------------------------------------------------------------
module header_table_size_accounting_top_test
    import htsa_pkg::*, htsa_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 2 * RING_DEPTH + 8;
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned LEN_MAX       = (1 << LEN_W) - 1;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_req            i_in_req    = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_req           o_out_req;
    logic               i_cfg_we    = 1'b0;
    logic [BYTES_W-1:0] i_cfg_wdata = '0;

    // idling odds in percent, changed per phase
    int unsigned        gap_pct     = 0;
    int unsigned        stall_pct   = 0;
    int unsigned        cycle_count = 0;

    htsa_table_tracker  tracker = new();

    header_table_size_accounting_top #(
        .MAX_ENTRIES (RING_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog, a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check what was taken at this edge, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_result(o_out_req);
        i_out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    // optional idle cycles, then hold the request until it is taken;
    // valid is only lowered when a gap actually follows
    task automatic push_request(input t_in_req req);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_req   <= req;
        i_in_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        tracker.note_request(req);
    endtask

    task automatic push_insert(input int unsigned name_len, input int unsigned value_len);
        t_in_req req;
        req.func         = FUNC_INSERT;
        req.name_length  = name_len[LEN_W-1:0];
        req.value_length = value_len[LEN_W-1:0];
        push_request(req);
    endtask

    // lengths are don't-care on a trim, so fill them with noise
    task automatic push_trim();
        t_in_req req;
        req.func         = FUNC_TRIM;
        req.name_length  = LEN_W'($urandom_range(0, LEN_MAX));
        req.value_length = LEN_W'($urandom_range(0, LEN_MAX));
        push_request(req);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (tracker.pending() != 0);
    endtask

    // only called with nothing in flight; a short pause lets the block settle
    task automatic write_budget(input logic [BYTES_W-1:0] value);
        repeat (4) @(posedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        tracker.set_budget(value);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly lengths scaled to the budget, some full-range and extreme ones
    function automatic logic [LEN_W-1:0] pick_length(input int unsigned cap, input bit wide);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (wide && roll < 10)
            return LEN_W'($urandom_range(0, LEN_MAX));
        if (wide && roll < 16)
            return $urandom_range(0, 1) ? LEN_MAX[LEN_W-1:0] : '0;
        return LEN_W'($urandom_range(0, cap));
    endfunction

    // tight phases keep entries tiny so the ring wraps and fills
    task automatic run_random_phase(input logic [BYTES_W-1:0] budget, input int unsigned count,
                                    input bit tight);
        t_in_req     req;
        int unsigned cap;
        cap = tight ? 12 : budget / 6;
        if (cap > LEN_MAX)
            cap = LEN_MAX;
        if (cap < 4)
            cap = 4;
        for (int unsigned k = 0; k < count; k++) begin
            req.func         = ($urandom_range(0, 99) < 12) ? FUNC_TRIM : FUNC_INSERT;
            req.name_length  = pick_length(cap, !tight);
            req.value_length = pick_length(cap, !tight);
            push_request(req);
        end
    endtask

    // idling modes: none, sender gaps, receiver stalls, both lightly
    task automatic set_idling(input int unsigned mode);
        case (mode % 4)
            0: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            1: begin
                gap_pct   = 82;
                stall_pct = 0;
            end
            2: begin
                gap_pct   = 0;
                stall_pct = 82;
            end
            default: begin
                gap_pct   = 26;
                stall_pct = 26;
            end
        endcase
    endtask

    function automatic logic [BYTES_W-1:0] budget_for(input int unsigned phase);
        case (phase)
            0:       return 16'hFFFF;
            1:       return 16'd1500;
            2:       return 16'd0;
            3:       return 16'd40;
            5:       return 16'hFFFF;
            6:       return 16'd300;
            7:       return BUDGET_RESET;
            9:       return 16'd32000;
            default: return BYTES_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial begin
        logic [BYTES_W-1:0] budget;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners at the reset budget of 4096
        push_insert(0, 0);                // smallest entry
        push_insert(LEN_MAX, LEN_MAX);    // oversized, empties the table
        push_trim();                      // trim on an empty table
        push_insert(2000, 2000);
        push_insert(10, 20);              // still fits alongside
        push_insert(0, 2);                // evicts the big one
        push_insert(4064, 0);             // exactly the budget, evicts all
        push_insert(0, 4065);             // one byte over
        push_insert(1000, 0);
        push_insert(1000, 0);
        push_insert(1000, 0);
        drain_results();

        // budget lowered without a trim, the next insert catches up
        write_budget(16'd1100);
        push_insert(0, 0);
        push_insert(500, 500);
        drain_results();
        write_budget(16'd100);
        push_trim();
        push_trim();
        drain_results();

        // zero budget: every insert is oversized, a trim empties everything
        write_budget(16'd0);
        push_insert(0, 0);
        push_trim();
        drain_results();

        // full-scale budget with the largest entries
        write_budget(16'hFFFF);
        push_insert(LEN_MAX, LEN_MAX);
        push_insert(LEN_MAX, LEN_MAX);
        push_insert(LEN_MAX, 16352);
        push_trim();

        // random phases, each with its own budget and idling mode
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            set_idling(phase);
            budget = budget_for(phase);
            write_budget(budget);
            if (phase == 0) begin
                run_random_phase(budget, 110, 1'b1);
            end else if (phase == 4) begin
                // sender holds off mid-phase until every result is back
                run_random_phase(budget, 30, 1'b0);
                drain_results();
                run_random_phase(budget, 30, 1'b0);
            end else begin
                run_random_phase(budget, 55, 1'b0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
